// ===== rtl/dtq_pkg.sv =====
// types, constants and helpers shared by the transfer queue sequencer
// no dependencies
`default_nettype none
package dtq_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t SLOTS_FULL = CNT_W'(NUM_SLOTS);

  localparam logic [5:0] PACING_FORCED = 6'h3f;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_EVENT  = 1'b1;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_FULL       = 3'd1;
  localparam logic [2:0] STAT_NO_CHANNEL = 3'd2;
  localparam logic [2:0] STAT_ZERO_COUNT = 3'd3;
  localparam logic [2:0] STAT_PACING     = 3'd4;
  localparam logic [2:0] STAT_IDLE_EVENT = 3'd5;

  typedef struct packed {
    logic        operation;
    logic        tx_sel;
    logic        rx_sel;
    logic [5:0]  tx_pacing;
    logic [5:0]  rx_pacing;
    logic [31:0] xfer_len;
    logic [7:0]  action_tag;
    logic        tx_finished;
    logic        rx_finished;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] assigned_slot;
    logic       launch;
    logic [1:0] launch_slot;
    logic       launch_tx;
    logic       launch_rx;
    logic       completed;
    logic [1:0] completed_slot;
    logic [7:0] completed_action;
    logic [2:0] queue_length;
    logic       busy_res;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_SUBMIT,
    CMD_REJECT,
    CMD_EVENT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] status;
    logic       tx_sel;
    logic       rx_sel;
    logic [7:0] action_tag;
    logic       tx_finished;
    logic       rx_finished;
  } cmd_t;

  typedef struct packed {
    logic       tx_sel;
    logic       rx_sel;
    logic [7:0] action;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    BK_EXEC  = 2'b01,
    BK_FETCH = 2'b10
  } back_state_t;

  function automatic idx_t ring_next(input idx_t s);
    ring_next = (s == idx_t'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dtq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module dtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/dtq_front.sv =====
// front end: accepts transactions, runs the stateless submit checks, queues commands
// depends on dtq_pkg
`default_nettype none
module dtq_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dtq_pkg::in_item_t in_data,
  output logic                 cmd_valid,
  input  wire logic            cmd_pop,
  output dtq_pkg::cmd_t        cmd
);
  import dtq_pkg::*;

  cmd_t                 fifo [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] fill;
  cmd_t                 classified;
  logic                 push;
  logic                 pop;

  always_comb begin
    classified             = '0;
    classified.tx_sel      = in_data.tx_sel;
    classified.rx_sel      = in_data.rx_sel;
    classified.action_tag  = in_data.action_tag;
    classified.tx_finished = in_data.tx_finished;
    classified.rx_finished = in_data.rx_finished;
    classified.status      = STAT_OK;
    if (in_data.operation == OP_EVENT) begin
      classified.kind = CMD_EVENT;
    end else if (!in_data.tx_sel && !in_data.rx_sel) begin
      classified.kind   = CMD_REJECT;
      classified.status = STAT_NO_CHANNEL;
    end else if (in_data.xfer_len == 32'd0) begin
      classified.kind   = CMD_REJECT;
      classified.status = STAT_ZERO_COUNT;
    end else if (in_data.tx_sel && in_data.rx_sel &&
                 in_data.tx_pacing == in_data.rx_pacing &&
                 in_data.tx_pacing != PACING_FORCED) begin
      classified.kind   = CMD_REJECT;
      classified.status = STAT_PACING;
    end else begin
      classified.kind = CMD_SUBMIT;
    end
  end

  assign in_ready  = (fill != CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = fifo[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dtq_back.sv =====
// back end: ring queue state, slot memory, launch and completion sequencing
// depends on dtq_pkg and dtq_ram
`default_nettype none
module dtq_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_pop,
  input  wire dtq_pkg::cmd_t    cmd,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dtq_pkg::out_item_t    out_data
);
  import dtq_pkg::*;

  back_state_t state, state_next;
  idx_t        head, head_next;
  idx_t        tail, tail_next;
  cnt_t        count, count_next;
  logic        running, running_next;
  logic        head_txf, head_txf_next;
  logic        head_rxf, head_rxf_next;
  logic [7:0]  head_action, head_action_next;
  logic        out_valid_next;
  out_item_t   out_data_next;

  logic        ram_we;
  idx_t        ram_raddr;
  slot_t       ram_wdata;
  slot_t       ram_rdata;

  dtq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NUM_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = ring_next(head);
  assign ram_wdata = '{tx_sel: cmd.tx_sel, rx_sel: cmd.rx_sel,
                       action: cmd.action_tag};

  always_comb begin
    logic fin_tx;
    logic fin_rx;
    cnt_t count_dec;
    fin_tx           = head_txf || cmd.tx_finished;
    fin_rx           = head_rxf || cmd.rx_finished;
    count_dec        = count - 1'b1;
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    running_next     = running;
    head_txf_next    = head_txf;
    head_rxf_next    = head_rxf;
    head_action_next = head_action;
    out_valid_next   = out_valid && !out_ready;
    out_data_next    = out_data;
    ram_we           = 1'b0;
    cmd_pop          = 1'b0;
    case (state)
      BK_EXEC: begin
        if (cmd_valid && (!out_valid || out_ready)) begin
          cmd_pop        = 1'b1;
          out_valid_next = 1'b1;
          out_data_next  = '0;
          case (cmd.kind)
            CMD_REJECT: begin
              out_data_next.status = cmd.status;
            end
            CMD_SUBMIT: begin
              if (count >= SLOTS_FULL) begin
                out_data_next.status = STAT_FULL;
              end else begin
                ram_we                      = 1'b1;
                out_data_next.assigned_slot = 2'(tail);
                tail_next                   = ring_next(tail);
                count_next                  = count + 1'b1;
                if (!running) begin
                  running_next              = 1'b1;
                  head_txf_next             = !cmd.tx_sel;
                  head_rxf_next             = !cmd.rx_sel;
                  head_action_next          = cmd.action_tag;
                  out_data_next.launch      = 1'b1;
                  out_data_next.launch_slot = 2'(tail);
                  out_data_next.launch_tx   = cmd.tx_sel;
                  out_data_next.launch_rx   = cmd.rx_sel;
                end
              end
            end
            CMD_EVENT: begin
              if (!running) begin
                out_data_next.status = STAT_IDLE_EVENT;
              end else if (fin_tx && fin_rx) begin
                out_data_next.completed        = 1'b1;
                out_data_next.completed_slot   = 2'(head);
                out_data_next.completed_action = head_action;
                head_next                      = ring_next(head);
                count_next                     = count_dec;
                if (count_dec != '0) begin
                  out_valid_next = 1'b0;
                  state_next     = BK_FETCH;
                end else begin
                  running_next = 1'b0;
                end
              end else begin
                head_txf_next = fin_tx;
                head_rxf_next = fin_rx;
              end
            end
            default: begin
              out_data_next.status = STAT_OK;
            end
          endcase
          out_data_next.queue_length = 3'(count_next);
          out_data_next.busy_res     = running_next;
        end
      end
      BK_FETCH: begin
        head_txf_next             = !ram_rdata.tx_sel;
        head_rxf_next             = !ram_rdata.rx_sel;
        head_action_next          = ram_rdata.action;
        out_valid_next            = 1'b1;
        out_data_next.launch      = 1'b1;
        out_data_next.launch_slot = 2'(head);
        out_data_next.launch_tx   = ram_rdata.tx_sel;
        out_data_next.launch_rx   = ram_rdata.rx_sel;
        state_next                = BK_EXEC;
      end
      default: begin
        state_next = BK_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_EXEC;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      running   <= running_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    head_txf    <= head_txf_next;
    head_rxf    <= head_rxf_next;
    head_action <= head_action_next;
    out_data    <= out_data_next;
  end

endmodule
`default_nettype wire

// ===== rtl/dma_transfer_queue_sequencer_top.sv =====
// path: a result passes the command queue and then the back end output register; a completion
// that launches a waiting slot also passes the fetch state (one slot memory read on the way)
// throughput: one transaction per cycle while out_ready does not hold the output, except a
// completion that launches a waiting slot, which holds the back end on the slot memory read port
// reset: clears pointers, count, running flag, command queue and output valid; the slot
// memory is not cleared and needs no clearing pass
`default_nettype none
module dma_transfer_queue_sequencer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dtq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dtq_pkg::out_item_t      out_data
);
  import dtq_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  dtq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  dtq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_reject_no_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STAT_OK |-> !out_data.launch && !out_data.completed)
    else $error("rejected transaction launched or completed a slot");

  a_launch_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.launch |->
      out_data.busy_res && (out_data.launch_tx || out_data.launch_rx))
    else $error("launch without running transfer or channel mask");

  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.completed && !out_data.launch |->
      !out_data.busy_res && out_data.queue_length == 3'd0)
    else $error("queue not empty after final completion");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.busy_res |-> out_data.queue_length == 3'd0)
    else $error("idle with occupied slots");

endmodule
`default_nettype wire
